// File: rtl/vrp_pkg.sv
// vrp_pkg: shared types, constants and arithmetic helpers for the vertex transform
// used by vertex_rotate_project, vrp_div and vrp_chk
// no dependencies
package vrp_pkg;

	localparam int VRP_CORDIC_N = 16;
	localparam int VRP_NUM_W    = 52;
	localparam int VRP_DEN_W    = 32;
	localparam int VRP_LAT      = 26 + VRP_NUM_W;
	localparam int VRP_CFG_W    = 4;

	localparam logic signed [32:0] VRP_CORDIC_GAIN = 33'sd652032874;
	localparam logic [11:0] VRP_WIDTH_RST  = 12'd640;
	localparam logic [11:0] VRP_HEIGHT_RST = 12'd480;
	localparam logic [15:0] VRP_TILT_RST   = 16'd10923;
	localparam logic [15:0] VRP_OFFSET_RST = 16'd150;

	typedef enum logic [VRP_CFG_W-1:0] {
		REG_WIDTH  = 4'd0,
		REG_HEIGHT = 4'd1,
		REG_TILT   = 4'd2,
		REG_OFFSET = 4'd3
	} vrp_reg_t;

	// arctangent of 2^-i in 1/65536 turn
	function automatic logic signed [17:0] atan_turn(input logic [3:0] i);
		logic signed [17:0] a;
		case (i)
			4'd0:    a = 18'sd8192;
			4'd1:    a = 18'sd4836;
			4'd2:    a = 18'sd2555;
			4'd3:    a = 18'sd1297;
			4'd4:    a = 18'sd651;
			4'd5:    a = 18'sd326;
			4'd6:    a = 18'sd163;
			4'd7:    a = 18'sd81;
			4'd8:    a = 18'sd41;
			4'd9:    a = 18'sd20;
			4'd10:   a = 18'sd10;
			4'd11:   a = 18'sd5;
			4'd12:   a = 18'sd3;
			4'd13:   a = 18'sd1;
			4'd14:   a = 18'sd1;
			default: a = 18'sd0;
		endcase
		return a;
	endfunction

	// shift right, halves rounded away from zero
	function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
			input int unsigned s);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? 64'(-v) : 64'(v);
		r = (mag + (64'd1 << (s - 1))) >> s;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

endpackage

// File: rtl/vrp_div.sv
// vrp_div: pipelined restoring divider, one quotient bit per stage
// uses vrp_pkg for default widths
module vrp_div
	import vrp_pkg::*;
#(
	parameter int NUM_W = VRP_NUM_W,
	parameter int DEN_W = VRP_DEN_W
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [0:NUM_W];
	logic [NUM_W-1:0] nq_s  [0:NUM_W];
	logic [DEN_W-1:0] dv_s  [0:NUM_W];

	assign rem_s[0] = '0;
	assign nq_s[0]  = num;
	assign dv_s[0]  = den;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W:0] r;
		logic           ge;
		assign r  = {rem_s[k], nq_s[k][NUM_W-1]};
		assign ge = r >= {1'b0, dv_s[k]};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? DEN_W'(r - {1'b0, dv_s[k]}) : r[DEN_W-1:0];
			nq_s[k+1]  <= {nq_s[k][NUM_W-2:0], ge};
			dv_s[k+1]  <= dv_s[k];
		end
	end

	assign quo = nq_s[NUM_W];

endmodule

// File: rtl/vertex_rotate_project.sv
// vertex_rotate_project: spin, tilt, offset and perspective projection of a planar vertex
// uses vrp_pkg and vrp_div
// start passes the cordic and divider pipeline to done; one vertex accepted every cycle
// depth set by two 16-step cordic lanes and three 52-stage divider lanes
// busy stays low and results cannot be stalled; config write ready is always high
// arst_n clears the config registers to 640, 480, 10923, 150 and all valid bits
module vertex_rotate_project
	import vrp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [15:0]   vert_x,
	input  logic signed [15:0]   vert_y,
	input  logic [15:0]          spin_angle,
	output logic                 done,
	output logic signed [31:0]   screen_x,
	output logic signed [31:0]   screen_y,
	output logic [31:0]          inv_depth,
	output logic                 depth_fault,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [VRP_CFG_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam int N = VRP_CORDIC_N;
	localparam int NW = VRP_NUM_W;
	localparam logic [NW-1:0] INV_ONE = NW'(64'd1 << 38);
	localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
	localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

	logic [11:0] width_q, height_q;
	logic [15:0] tilt_q, offset_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= VRP_WIDTH_RST;
			height_q <= VRP_HEIGHT_RST;
			tilt_q   <= VRP_TILT_RST;
			offset_q <= VRP_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[11:0];
				REG_HEIGHT: height_q <= cfg_data[11:0];
				REG_TILT:   tilt_q   <= cfg_data;
				REG_OFFSET: offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// angle fold into +-quarter turn
	logic signed [17:0] sz0, tz0;
	logic               sf0, tf0;

	always_comb begin
		logic signed [17:0] a;
		a = 18'(signed'(spin_angle));
		sf0 = 1'b0;
		sz0 = a;
		if (a > 18'sd16384) begin
			sz0 = a - 18'sd32768;
			sf0 = 1'b1;
		end else if (a < -18'sd16384) begin
			sz0 = a + 18'sd32768;
			sf0 = 1'b1;
		end
	end

	always_comb begin
		logic signed [17:0] a;
		a = 18'(signed'(tilt_q));
		tf0 = 1'b0;
		tz0 = a;
		if (a > 18'sd16384) begin
			tz0 = a - 18'sd32768;
			tf0 = 1'b1;
		end else if (a < -18'sd16384) begin
			tz0 = a + 18'sd32768;
			tf0 = 1'b1;
		end
	end

	// cordic lanes, index 0 is the fold register
	logic signed [32:0] sx_s1 [0:N];
	logic signed [32:0] sy_s1 [0:N];
	logic signed [17:0] sz_s1 [0:N];
	logic signed [32:0] tx_s1 [0:N];
	logic signed [32:0] ty_s1 [0:N];
	logic signed [17:0] tz_s1 [0:N];
	logic               sf_s1 [0:N];
	logic               tf_s1 [0:N];
	logic signed [15:0] vx_s1 [0:N];
	logic signed [15:0] vy_s1 [0:N];
	logic [N:0]         vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= '0;
		else         vld_s1 <= {vld_s1[N-1:0], start && !busy};
	end

	always_ff @(posedge clk) begin
		sx_s1[0] <= VRP_CORDIC_GAIN;
		sy_s1[0] <= '0;
		sz_s1[0] <= sz0;
		tx_s1[0] <= VRP_CORDIC_GAIN;
		ty_s1[0] <= '0;
		tz_s1[0] <= tz0;
		sf_s1[0] <= sf0;
		tf_s1[0] <= tf0;
		vx_s1[0] <= vert_x;
		vy_s1[0] <= vert_y;
	end

	for (genvar k = 0; k < N; k++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (sz_s1[k] >= 0) begin
				sx_s1[k+1] <= sx_s1[k] - (sy_s1[k] >>> k);
				sy_s1[k+1] <= sy_s1[k] + (sx_s1[k] >>> k);
				sz_s1[k+1] <= sz_s1[k] - atan_turn(4'(k));
			end else begin
				sx_s1[k+1] <= sx_s1[k] + (sy_s1[k] >>> k);
				sy_s1[k+1] <= sy_s1[k] - (sx_s1[k] >>> k);
				sz_s1[k+1] <= sz_s1[k] + atan_turn(4'(k));
			end
			if (tz_s1[k] >= 0) begin
				tx_s1[k+1] <= tx_s1[k] - (ty_s1[k] >>> k);
				ty_s1[k+1] <= ty_s1[k] + (tx_s1[k] >>> k);
				tz_s1[k+1] <= tz_s1[k] - atan_turn(4'(k));
			end else begin
				tx_s1[k+1] <= tx_s1[k] + (ty_s1[k] >>> k);
				ty_s1[k+1] <= ty_s1[k] - (tx_s1[k] >>> k);
				tz_s1[k+1] <= tz_s1[k] + atan_turn(4'(k));
			end
			sf_s1[k+1] <= sf_s1[k];
			tf_s1[k+1] <= tf_s1[k];
			vx_s1[k+1] <= vx_s1[k];
			vy_s1[k+1] <= vy_s1[k];
		end
	end

	// q14 sine and cosine
	logic signed [16:0] cb_s3, sb_s3, ca_s3, sa_s3;
	logic signed [15:0] vx_s3, vy_s3;
	logic               vld_s3;

	always_ff @(posedge clk) begin
		cb_s3 <= 17'(sf_s1[N] ? -rnd_sh(64'(sx_s1[N]), 16) : rnd_sh(64'(sx_s1[N]), 16));
		sb_s3 <= 17'(sf_s1[N] ? -rnd_sh(64'(sy_s1[N]), 16) : rnd_sh(64'(sy_s1[N]), 16));
		ca_s3 <= 17'(tf_s1[N] ? -rnd_sh(64'(tx_s1[N]), 16) : rnd_sh(64'(tx_s1[N]), 16));
		sa_s3 <= 17'(tf_s1[N] ? -rnd_sh(64'(ty_s1[N]), 16) : rnd_sh(64'(ty_s1[N]), 16));
		vx_s3 <= vx_s1[N];
		vy_s3 <= vy_s1[N];
	end

	// spin products
	logic signed [32:0] cbx_s4, sby_s4, sbx_s4, cby_s4;
	logic signed [16:0] ca_s4, sa_s4;
	logic               vld_s4;

	always_ff @(posedge clk) begin
		cbx_s4 <= cb_s3 * vx_s3;
		sby_s4 <= sb_s3 * vy_s3;
		sbx_s4 <= sb_s3 * vx_s3;
		cby_s4 <= cb_s3 * vy_s3;
		ca_s4  <= ca_s3;
		sa_s4  <= sa_s3;
	end

	logic signed [33:0] x14_s5, t_s5;
	logic signed [16:0] ca_s5, sa_s5;
	logic               vld_s5;

	always_ff @(posedge clk) begin
		x14_s5 <= 34'(cbx_s4) - 34'(sby_s4);
		t_s5   <= 34'(sbx_s4) + 34'(cby_s4);
		ca_s5  <= ca_s4;
		sa_s5  <= sa_s4;
	end

	// tilt products
	logic signed [50:0] cat_s6, sat_s6;
	logic signed [33:0] x14_s6;
	logic               vld_s6;

	always_ff @(posedge clk) begin
		cat_s6 <= ca_s5 * t_s5;
		sat_s6 <= sa_s5 * t_s5;
		x14_s6 <= x14_s5;
	end

	logic signed [37:0] y14_s7, zr_s7;
	logic signed [33:0] x14_s7;
	logic               vld_s7;

	always_ff @(posedge clk) begin
		y14_s7 <= 38'(rnd_sh(64'(cat_s6), 14));
		zr_s7  <= 38'(rnd_sh(64'(sat_s6), 14));
		x14_s7 <= x14_s6;
	end

	// depth and fault
	logic signed [39:0] z_sum;
	logic               z_bad;

	assign z_sum = 40'(zr_s7) + 40'({1'b0, offset_q, 14'b0});
	assign z_bad = z_sum[39] || (z_sum == '0);

	logic [31:0]        den_s8;
	logic               fault_s8;
	logic signed [37:0] y14_s8;
	logic signed [33:0] x14_s8;
	logic               vld_s8;

	always_ff @(posedge clk) begin
		den_s8   <= z_bad ? 32'd1 : z_sum[31:0];
		fault_s8 <= z_bad;
		y14_s8   <= y14_s7;
		x14_s8   <= x14_s7;
	end

	// scale by height
	logic signed [46:0] mx_s9;
	logic signed [50:0] my_s9;
	logic [31:0]        den_s9;
	logic               fault_s9;
	logic               vld_s9;

	always_ff @(posedge clk) begin
		mx_s9    <= x14_s8 * $signed({1'b0, height_q});
		my_s9    <= y14_s8 * $signed({1'b0, height_q});
		den_s9   <= den_s8;
		fault_s9 <= fault_s8;
	end

	// divider numerators, magnitude plus half the divisor
	logic [46:0] magx;
	logic [50:0] magy;

	assign magx = mx_s9[46] ? 47'(-mx_s9) : 47'(mx_s9);
	assign magy = my_s9[50] ? 51'(-my_s9) : 51'(my_s9);

	logic [NW-1:0] nx_s10, ny_s10, ni_s10;
	logic [31:0]   den_s10;
	logic          fault_s10, negx_s10, negy_s10;
	logic          vld_s10;

	always_ff @(posedge clk) begin
		nx_s10    <= NW'({magx[42:0], 8'b0}) + NW'(den_s9 >> 1);
		ny_s10    <= NW'({magy[42:0], 8'b0}) + NW'(den_s9 >> 1);
		ni_s10    <= INV_ONE + NW'(den_s9 >> 1);
		den_s10   <= den_s9;
		fault_s10 <= fault_s9;
		negx_s10  <= mx_s9[46];
		negy_s10  <= my_s9[50];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s3  <= vld_s1[N];
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	logic [NW-1:0] qx, qy, qi;

	vrp_div #(.NUM_W(NW), .DEN_W(VRP_DEN_W)) u_div_x (
		.clk(clk), .num(nx_s10), .den(den_s10), .quo(qx)
	);
	vrp_div #(.NUM_W(NW), .DEN_W(VRP_DEN_W)) u_div_y (
		.clk(clk), .num(ny_s10), .den(den_s10), .quo(qy)
	);
	vrp_div #(.NUM_W(NW), .DEN_W(VRP_DEN_W)) u_div_i (
		.clk(clk), .num(ni_s10), .den(den_s10), .quo(qi)
	);

	// side band alongside the dividers
	logic [NW-1:0] vld_s11, fault_s11, negx_s11, negy_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s11 <= '0;
		else         vld_s11 <= {vld_s11[NW-2:0], vld_s10};
	end

	always_ff @(posedge clk) begin
		fault_s11 <= {fault_s11[NW-2:0], fault_s10};
		negx_s11  <= {negx_s11[NW-2:0], negx_s10};
		negy_s11  <= {negy_s11[NW-2:0], negy_s10};
	end

	// sign, center and saturate
	logic [33:0]        qcx, qcy;
	logic signed [35:0] px, py, sumx, sumy;
	logic signed [31:0] satx, saty;

	always_comb begin
		qcx  = (|qx[NW-1:33]) ? 34'h2_0000_0000 : qx[33:0];
		qcy  = (|qy[NW-1:33]) ? 34'h2_0000_0000 : qy[33:0];
		px   = negx_s11[NW-1] ? -$signed(36'(qcx)) : $signed(36'(qcx));
		py   = negy_s11[NW-1] ? -$signed(36'(qcy)) : $signed(36'(qcy));
		sumx = $signed(36'({width_q[11:1], 8'b0})) + px;
		sumy = $signed(36'({height_q[11:1], 8'b0})) - py;
		if (sumx > SAT_HI)      satx = 32'sh7FFF_FFFF;
		else if (sumx < SAT_LO) satx = -32'sh8000_0000;
		else                    satx = sumx[31:0];
		if (sumy > SAT_HI)      saty = 32'sh7FFF_FFFF;
		else if (sumy < SAT_LO) saty = -32'sh8000_0000;
		else                    saty = sumy[31:0];
	end

	logic               done_s12;
	logic signed [31:0] sx_s12, sy_s12;
	logic [31:0]        inv_s12;
	logic               fault_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_s12 <= 1'b0;
		else         done_s12 <= vld_s11[NW-1];
	end

	always_ff @(posedge clk) begin
		fault_s12 <= fault_s11[NW-1];
		if (fault_s11[NW-1]) begin
			sx_s12  <= '0;
			sy_s12  <= '0;
			inv_s12 <= '0;
		end else begin
			sx_s12  <= satx;
			sy_s12  <= saty;
			inv_s12 <= (|qi[NW-1:32]) ? 32'hFFFF_FFFF : qi[31:0];
		end
	end

	assign done        = done_s12;
	assign screen_x    = sx_s12;
	assign screen_y    = sy_s12;
	assign inv_depth   = inv_s12;
	assign depth_fault = fault_s12;

endmodule

// File: rtl/vrp_chk.sv
// vrp_sva: port-level checks for vertex_rotate_project, bound to the top level
// uses vrp_pkg for the pipeline latency
module vrp_sva
	import vrp_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic signed [15:0]   vert_x,
	input logic signed [15:0]   vert_y,
	input logic [15:0]          spin_angle,
	input logic                 done,
	input logic signed [31:0]   screen_x,
	input logic signed [31:0]   screen_y,
	input logic [31:0]          inv_depth,
	input logic                 depth_fault,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [VRP_CFG_W-1:0] cfg_index,
	input logic [15:0]          cfg_data
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && depth_fault |-> screen_x == 0 && screen_y == 0 && inv_depth == 0)
		else $error("faulted word carries nonzero fields");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, VRP_LAT))
		else $error("result word without matching start");

endmodule

bind vertex_rotate_project vrp_sva u_vrp_sva (.*);

// File: bench/vrp_chk.sv
`timescale 1ns / 100ps
// vrp_chk: watches the vertex, result and config channels of vertex_rotate_project,
// predicts each projected word and compares it field by field; depends on vrp_pkg
module vrp_chk
	import vrp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] vert_x,
	input  logic signed [15:0] vert_y,
	input  logic [15:0]        spin_angle,
	input  logic               done,
	input  logic signed [31:0] screen_x,
	input  logic signed [31:0] screen_y,
	input  logic [31:0]        inv_depth,
	input  logic               depth_fault,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [VRP_CFG_W-1:0] cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 fail_count,
	output int                 pending
);

	typedef struct {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic [31:0]        inv;
		logic               fault;
	} proj_t;

	localparam int ATAN_TURN [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0};

	logic [11:0] width_q, height_q;
	logic [15:0] tilt_q, offset_q;
	proj_t       proj_q[$];

	function automatic longint half_away_shift(input longint v, input int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint half_away_div(input longint num, input longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	task automatic turn_sincos(input logic [15:0] ang, output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit     flip;
		z = ang;
		flip = 0;
		x = 652032874;
		y = 0;
		if (z >= 32768)
			z -= 65536;
		if (z > 16384) begin
			z -= 32768;
			flip = 1;
		end else if (z < -16384) begin
			z += 32768;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_TURN[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_TURN[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = half_away_shift(x, 16);
		s = half_away_shift(y, 16);
	endtask

	task automatic project_vertex(input logic signed [15:0] vx, input logic signed [15:0] vy,
			input logic [15:0] spin, output proj_t p);
		longint ca, sa, cb, sb, x14, t, y14, z14, inv, h;
		turn_sincos(tilt_q, ca, sa);
		turn_sincos(spin, cb, sb);
		x14 = cb * longint'(vx) - sb * longint'(vy);
		t = sb * longint'(vx) + cb * longint'(vy);
		y14 = half_away_shift(ca * t, 14);
		z14 = half_away_shift(sa * t, 14) + longint'(offset_q) * 16384;
		if (z14 <= 0) begin
			p = '{0, 0, 0, 1'b1};
			return;
		end
		inv = ((longint'(1) << 38) + z14 / 2) / z14;
		if (inv > 64'sd4294967295)
			inv = 64'sd4294967295;
		h = longint'(height_q);
		p.sx = 32'(clamp32(longint'(width_q >> 1) * 256 + half_away_div(x14 * h * 256, z14)));
		p.sy = 32'(clamp32(longint'(height_q >> 1) * 256 - half_away_div(y14 * h * 256, z14)));
		p.inv = 32'(inv);
		p.fault = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		proj_t p, e;
		if (!arst_n) begin
			width_q <= VRP_WIDTH_RST;
			height_q <= VRP_HEIGHT_RST;
			tilt_q <= VRP_TILT_RST;
			offset_q <= VRP_OFFSET_RST;
			fail_count <= 0;
			proj_q.delete();
		end else begin
			if (start && !busy) begin
				project_vertex(vert_x, vert_y, spin_angle, p);
				proj_q.push_back(p);
			end
			if (done) begin
				if (proj_q.size() == 0) begin
					$error("result word with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = proj_q.pop_front();
					if (screen_x !== e.sx) $error("screen_x exp %0d got %0d", e.sx, screen_x);
					if (screen_y !== e.sy) $error("screen_y exp %0d got %0d", e.sy, screen_y);
					if (inv_depth !== e.inv) $error("inv_depth exp %0d got %0d", e.inv, inv_depth);
					if (depth_fault !== e.fault)
						$error("depth_fault exp %0d got %0d", e.fault, depth_fault);
					if (screen_x !== e.sx || screen_y !== e.sy || inv_depth !== e.inv
							|| depth_fault !== e.fault)
						fail_count <= fail_count + 1;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:  width_q <= cfg_data[11:0];
					REG_HEIGHT: height_q <= cfg_data[11:0];
					REG_TILT:   tilt_q <= cfg_data;
					REG_OFFSET: offset_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign pending = proj_q.size();

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// testbench: drives vertices and config writes into vertex_rotate_project in phases
// with varied idling; depends on vrp_pkg, vertex_rotate_project and vrp_chk
module testbench;
	import vrp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic signed [15:0] vert_x = 0;
	logic signed [15:0] vert_y = 0;
	logic [15:0]        spin_angle = 0;
	logic               done;
	logic signed [31:0] screen_x, screen_y;
	logic [31:0]        inv_depth;
	logic               depth_fault;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [VRP_CFG_W-1:0] cfg_index = '0;
	logic [15:0]        cfg_data = 0;
	int                 fail_count, pending;
	int                 idle_pct = 0;
	int                 cycles = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	vertex_rotate_project u_top (.*);
	vrp_chk u_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic send_vertex(input logic [15:0] x, input logic [15:0] y, input logic [15:0] a);
		logic b;
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		vert_x <= x;
		vert_y <= y;
		spin_angle <= a;
		do begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
		end while (b);
	endtask

	task automatic write_reg(input logic [VRP_CFG_W-1:0] idx, input logic [15:0] d);
		logic r;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do begin
			@(negedge clk);
			r = cfg_ready;
			@(posedge clk);
		end while (!r);
		cfg_valid <= 0;
	endtask

	task automatic drain;
		start <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (VRP_LAT + 10) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] w, input logic [15:0] h, input logic [15:0] t,
			input logic [15:0] o);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_TILT, t);
		write_reg(REG_OFFSET, o);
	endtask

	task automatic random_vertices(input int n);
		logic [15:0] x, y;
		for (int i = 0; i < n; i++) begin
			x = $urandom;
			y = $urandom;
			if ($urandom_range(3) == 0) begin
				x = 16'($signed(10'($urandom)));
				y = 16'($signed(10'($urandom)));
			end
			send_vertex(x, y, $urandom);
		end
	endtask

	initial begin
		logic [15:0] ext [6];
		ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, quarter turns, depth fault at reset tilt
		for (int i = 0; i < 6; i++)
			send_vertex(ext[i], ext[5 - i], ext[i]);
		send_vertex(16'h0000, 16'h8000, 16'd0);
		send_vertex(16'h7fff, 16'h7fff, 16'd16384);
		send_vertex(16'h8000, 16'h7fff, 16'd32768);
		send_vertex(16'h0064, 16'hff9c, 16'd49152);
		send_vertex(16'h0000, 16'h0000, 16'd8192);
		send_vertex(16'h8000, 16'h8000, 16'd24576);
		drain();
		write_reg(4'd9, 16'h1234);
		write_reg(4'd15, 16'hffff);
		set_regs(16'hf000, 16'h0000, 16'd0, 16'd0);
		send_vertex(16'h7fff, 16'h8000, 16'd12345);
		send_vertex(16'h0010, 16'h0020, 16'd0);
		drain();
		set_regs(16'hffff, 16'hffff, 16'd49152, 16'd1);
		send_vertex(16'h0000, 16'h0001, 16'd0);
		send_vertex(16'h0000, 16'hffff, 16'd0);
		send_vertex(16'h0000, 16'h0000, 16'd0);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(16'd640, 16'd480, 16'd10923, 16'd150);
				1: set_regs(16'd4095, 16'd4095, 16'd65535, 16'd65535);
				2: set_regs(16'd1, 16'd1, 16'd16384, 16'd0);
				3: set_regs(16'd1920, 16'd1080, 16'd32768, 16'd40000);
				default: set_regs($urandom, $urandom, $urandom, $urandom_range(2000));
			endcase
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 86;
				2: idle_pct = 0;
				default: idle_pct = 24;
			endcase
			random_vertices(320);
			start <= 0;
			repeat ($urandom_range(6)) @(posedge clk);
			drain();
		end
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: files.f
rtl/vrp_pkg.sv
rtl/vrp_div.sv
rtl/vertex_rotate_project.sv
rtl/vrp_chk.sv
bench/vrp_chk.sv
bench/testbench.sv
